FILE: design/assert_macros.svh
// Assertion macros for the line editor ring buffer RTL, included by lerb_ctrl.
// Both macros expect signals named clk and rst in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication within the same cycle, checked outside reset.
`define LERB_ASSERT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Implication into the following cycle, checked outside reset.
`define LERB_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: design/lerb_pkg.sv
// Shared types and codes for the line editor ring buffer.
// Used by lerb_store, lerb_ctrl and line_editor_ring_buffer_core; depends on nothing.
package lerb_pkg;

  localparam int ADDR_W = 16;

  localparam logic [3:0] KIND_CHAR      = 4'd0;
  localparam logic [3:0] KIND_ENTER     = 4'd1;
  localparam logic [3:0] KIND_LEFT      = 4'd2;
  localparam logic [3:0] KIND_RIGHT     = 4'd3;
  localparam logic [3:0] KIND_HOME      = 4'd4;
  localparam logic [3:0] KIND_END       = 4'd5;
  localparam logic [3:0] KIND_DELETE    = 4'd6;
  localparam logic [3:0] KIND_BACKSPACE = 4'd7;
  localparam logic [3:0] KIND_OTHER     = 4'd8;
  localparam logic [3:0] KIND_READ      = 4'd9;

  localparam logic [2:0] STAT_NONE    = 3'd0;
  localparam logic [2:0] STAT_EDIT    = 3'd1;
  localparam logic [2:0] STAT_LINE    = 3'd2;
  localparam logic [2:0] STAT_PASSED  = 3'd3;
  localparam logic [2:0] STAT_READ    = 3'd4;

  localparam logic CFG_INPUT_ENABLED = 1'b0;
  localparam logic CFG_EDITING_ON    = 1'b1;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  key_value;
    logic [10:0] read_offset;
    logic        flush_line;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  passed_key;
    logic [7:0]  read_char;
    logic [10:0] line_length;
    logic [10:0] cursor_back;
    logic [10:0] line_start;
  } out_item_t;

  typedef struct packed {
    logic              input_enabled;
    logic              editing_on;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MOVE,
    ST_TAIL1,
    ST_TAIL2,
    ST_REDUCE,
    ST_RWAIT,
    ST_DONE
  } lerb_state_t;

endpackage

FILE: design/lerb_store.sv
// Character ring storage: one write port and one registered read port.
// Depends on lerb_pkg for the memory request type.
module lerb_store #(
  parameter int RING_DEPTH = 2048
) (
  input  logic               clk,
  input  lerb_pkg::mem_req_t req,
  output logic [7:0]         rdata
);
  import lerb_pkg::*;

  localparam int PW = $clog2(RING_DEPTH);

  logic [7:0] mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[PW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr[PW-1:0]];
    end
  end

endmodule

FILE: design/lerb_ctrl.sv
// Sequencer for the line editor: pointers, cursor, character moves and the result register.
// Depends on lerb_pkg and assert_macros.svh; drives the lerb_store request port.
`include "assert_macros.svh"

module lerb_ctrl #(
  parameter int RING_DEPTH = 2048
) (
  input  logic                clk,
  input  logic                rst,
  input  lerb_pkg::cfg_t      cfg,
  input  logic                item_valid,
  output logic                item_stall,
  input  lerb_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_stall,
  output lerb_pkg::out_item_t result,
  output lerb_pkg::mem_req_t  mem_req,
  input  logic [7:0]          rdata
);
  import lerb_pkg::*;

  localparam int PW = $clog2(RING_DEPTH);
  localparam int SW = ((PW > 11) ? PW : 11) + 1;
  localparam logic [PW-1:0] LAST    = PW'(RING_DEPTH - 1);
  localparam logic [PW:0]   DEPTH_X = (PW + 1)'(RING_DEPTH);
  localparam logic [SW-1:0] DEPTH_S = SW'(RING_DEPTH);

  function automatic logic [PW-1:0] r_inc(input logic [PW-1:0] a);
    return (a == LAST) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [PW-1:0] r_dec(input logic [PW-1:0] a);
    return (a == '0) ? LAST : a - 1'b1;
  endfunction

  function automatic logic [PW-1:0] r_sub(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [PW:0] t;
    if (a >= b) begin
      t = {1'b0, a} - {1'b0, b};
    end else begin
      t = {1'b0, a} + DEPTH_X - {1'b0, b};
    end
    return t[PW-1:0];
  endfunction

  function automatic logic [10:0] low11(input logic [PW-1:0] a);
    logic [31:0] w;
    w = 32'(a);
    return w[10:0];
  endfunction

  lerb_state_t   state, state_next;
  logic [PW-1:0] end_ptr, begin_ptr, prev_ptr, cursor_dist;
  in_item_t      item_r;
  logic [2:0]    res_status;
  logic [7:0]    res_passed, res_rd, ins_char;
  logic [PW-1:0] mv_dst, mv_cnt, pend_dst;
  logic          mv_ins, pend, set_begin;
  logic [SW-1:0] rsum;

  logic [PW-1:0] cur_len, back_eff, mv_src, del_pos, bs_pos;
  logic          ring_full, enter_full;
  logic [3:0]    kind_e;

  lerb_state_t   ex_next;
  logic [2:0]    ex_status;
  logic [7:0]    ex_passed, ex_ins_char;
  logic [PW-1:0] ex_end, ex_begin, ex_prev, ex_cursor, ex_mv_dst, ex_mv_cnt;
  logic          ex_mv_ins, ex_set_begin, ex_clear_we;

  assign cur_len    = r_sub(end_ptr, begin_ptr);
  assign ring_full  = (r_inc(r_inc(end_ptr)) == prev_ptr);
  assign enter_full = (r_inc(r_inc(end_ptr)) == begin_ptr);
  assign back_eff  = cfg.editing_on ? ((cursor_dist > cur_len) ? cur_len : cursor_dist) : '0;
  assign mv_src    = mv_ins ? r_dec(mv_dst) : r_inc(mv_dst);
  assign del_pos   = r_sub(end_ptr, cursor_dist);
  assign bs_pos    = r_sub(end_ptr, cursor_dist + 1'b1);
  assign kind_e    = ((item_r.kind == KIND_CHAR) &&
                      ((item_r.key_value == CHAR_LF) || (item_r.key_value == CHAR_CR)))
                     ? KIND_ENTER : item_r.kind;

  always_comb begin
    ex_next      = ST_DONE;
    ex_status    = STAT_NONE;
    ex_passed    = '0;
    ex_ins_char  = item_r.key_value;
    ex_end       = end_ptr;
    ex_begin     = begin_ptr;
    ex_prev      = prev_ptr;
    ex_cursor    = cursor_dist;
    ex_mv_dst    = end_ptr;
    ex_mv_cnt    = '0;
    ex_mv_ins    = 1'b1;
    ex_set_begin = 1'b0;
    ex_clear_we  = 1'b0;
    if (item_r.kind == KIND_READ) begin
      if (item_r.flush_line) begin
        ex_end      = begin_ptr;
        ex_cursor   = '0;
        ex_clear_we = 1'b1;
        ex_status   = STAT_EDIT;
      end else begin
        ex_next   = ST_REDUCE;
        ex_status = STAT_READ;
      end
    end else if ((item_r.kind <= KIND_OTHER) && cfg.input_enabled) begin
      if (kind_e == KIND_CHAR) begin
        if ((item_r.key_value != CHAR_NUL) && !ring_full) begin
          ex_status = STAT_EDIT;
          ex_mv_cnt = back_eff;
          ex_next   = ST_MOVE;
        end
      end else if (kind_e == KIND_ENTER) begin
        ex_prev   = begin_ptr;
        ex_cursor = '0;
        ex_status = STAT_LINE;
        if (enter_full) begin
          ex_begin = end_ptr;
        end else begin
          ex_ins_char  = CHAR_NUL;
          ex_set_begin = 1'b1;
          ex_next      = ST_MOVE;
        end
      end else if (!cfg.editing_on || (kind_e == KIND_OTHER)) begin
        ex_passed = item_r.key_value;
        ex_status = STAT_PASSED;
      end else begin
        case (kind_e)
          KIND_LEFT: begin
            if (cursor_dist < cur_len) begin
              ex_cursor = cursor_dist + 1'b1;
            end
            ex_status = STAT_EDIT;
          end
          KIND_RIGHT: begin
            if (cursor_dist != '0) begin
              ex_cursor = cursor_dist - 1'b1;
            end
            ex_status = STAT_EDIT;
          end
          KIND_HOME: begin
            ex_cursor = cur_len;
            ex_status = STAT_EDIT;
          end
          KIND_END: begin
            ex_cursor = '0;
            ex_status = STAT_EDIT;
          end
          KIND_DELETE: begin
            if ((cursor_dist != '0) && (cursor_dist <= cur_len)) begin
              ex_cursor = cursor_dist - 1'b1;
              ex_end    = r_dec(end_ptr);
              ex_mv_dst = del_pos;
              ex_mv_cnt = r_sub(r_dec(end_ptr), del_pos);
              ex_mv_ins = 1'b0;
              ex_next   = ST_MOVE;
              ex_status = STAT_EDIT;
            end
          end
          KIND_BACKSPACE: begin
            if (cursor_dist < cur_len) begin
              ex_end    = r_dec(end_ptr);
              ex_mv_dst = bs_pos;
              ex_mv_cnt = r_sub(r_dec(end_ptr), bs_pos);
              ex_mv_ins = 1'b0;
              ex_next   = ST_MOVE;
              ex_status = STAT_EDIT;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ex_next;
      end
      ST_MOVE: begin
        if (mv_cnt == '0) begin
          state_next = ST_TAIL1;
        end
      end
      ST_TAIL1: begin
        state_next = mv_ins ? ST_TAIL2 : ST_DONE;
      end
      ST_TAIL2: begin
        state_next = ST_DONE;
      end
      ST_REDUCE: begin
        if (rsum < DEPTH_S) begin
          state_next = ST_RWAIT;
        end
      end
      ST_RWAIT: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!result_valid || !result_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    item_stall = (state != ST_IDLE);
    mem_req    = '0;
    case (state)
      ST_EXEC: begin
        mem_req.we    = ex_clear_we;
        mem_req.waddr = ADDR_W'(begin_ptr);
        mem_req.wdata = CHAR_NUL;
      end
      ST_MOVE: begin
        mem_req.we    = pend;
        mem_req.waddr = ADDR_W'(pend_dst);
        mem_req.wdata = rdata;
        mem_req.re    = (mv_cnt != '0);
        mem_req.raddr = ADDR_W'(mv_src);
      end
      ST_TAIL1: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ADDR_W'(mv_dst);
        mem_req.wdata = mv_ins ? ins_char : CHAR_NUL;
      end
      ST_TAIL2: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ADDR_W'(r_inc(end_ptr));
        mem_req.wdata = CHAR_NUL;
      end
      ST_REDUCE: begin
        mem_req.re    = (rsum < DEPTH_S);
        mem_req.raddr = ADDR_W'(rsum[PW-1:0]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      end_ptr      <= '0;
      begin_ptr    <= '0;
      prev_ptr     <= '0;
      cursor_dist  <= '0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ST_IDLE) && item_valid) begin
        item_r <= item;
      end
      if (state == ST_EXEC) begin
        end_ptr     <= ex_end;
        begin_ptr   <= ex_begin;
        prev_ptr    <= ex_prev;
        cursor_dist <= ex_cursor;
        res_status  <= ex_status;
        res_passed  <= ex_passed;
        res_rd      <= '0;
        ins_char    <= ex_ins_char;
        mv_dst      <= ex_mv_dst;
        mv_cnt      <= ex_mv_cnt;
        mv_ins      <= ex_mv_ins;
        set_begin   <= ex_set_begin;
        pend        <= 1'b0;
        rsum        <= SW'(prev_ptr) + SW'(item_r.read_offset);
      end
      if (state == ST_MOVE) begin
        if (mv_cnt != '0) begin
          pend     <= 1'b1;
          pend_dst <= mv_dst;
          mv_dst   <= mv_src;
          mv_cnt   <= mv_cnt - 1'b1;
        end else begin
          pend <= 1'b0;
        end
      end
      if (state == ST_TAIL2) begin
        end_ptr <= r_inc(end_ptr);
        if (set_begin) begin
          begin_ptr <= r_inc(end_ptr);
        end
      end
      if ((state == ST_REDUCE) && (rsum >= DEPTH_S)) begin
        rsum <= rsum - DEPTH_S;
      end
      if (state == ST_RWAIT) begin
        res_rd <= rdata;
      end
      if ((state == ST_DONE) && (!result_valid || !result_stall)) begin
        result_valid       <= 1'b1;
        result.status      <= res_status;
        result.passed_key  <= res_passed;
        result.read_char   <= res_rd;
        result.line_length <= low11(cur_len);
        result.cursor_back <= low11(cursor_dist);
        result.line_start  <= low11(prev_ptr);
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  `LERB_ASSERT(a_cursor_in_line, state == ST_IDLE, cursor_dist <= cur_len, "cursor beyond line end")
  `LERB_ASSERT(a_no_rw_clash, mem_req.we && mem_req.re, mem_req.waddr != mem_req.raddr, "read and write hit one entry")
  `LERB_ASSERT_NEXT(a_accept_exec, item_valid && !item_stall, state == ST_EXEC, "accepted beat not executed")
  `LERB_ASSERT_NEXT(a_move_drain, (state == ST_MOVE) && (mv_cnt == '0), (state == ST_TAIL1) && !pend, "move did not drain")

endmodule

FILE: design/line_editor_ring_buffer_core.sv
// Line editor ring buffer top level: configuration registers, sequencer and character store.
// Each accepted beat is executed; a character first shifts the characters after the cursor, an
// enter writes its terminators, a delete or backspace moves characters back, and a read reduces
// line_start + read_offset below RING_DEPTH and reads the store, then the result register loads.
// One beat is in work at a time; the next is taken in the cycle after the result loads.
// Reset clears pointers and cursor and sets input enabled, editing off; the store is not cleared.
module line_editor_ring_buffer_core #(
  parameter int RING_DEPTH = 2048
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic                cfg_data,
  input  logic                item_valid,
  output logic                item_stall,
  input  lerb_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_stall,
  output lerb_pkg::out_item_t result
);
  import lerb_pkg::*;

  cfg_t       cfg;
  mem_req_t   mem_req;
  logic [7:0] rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.input_enabled <= 1'b1;
      cfg.editing_on    <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_INPUT_ENABLED: cfg.input_enabled <= cfg_data;
        CFG_EDITING_ON:    cfg.editing_on    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lerb_ctrl #(
    .RING_DEPTH(RING_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .mem_req      (mem_req),
    .rdata        (rdata)
  );

  lerb_store #(
    .RING_DEPTH(RING_DEPTH)
  ) u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

endmodule

FILE: sim/line_editor_ring_buffer_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for line_editor_ring_buffer_core: directed and random key events,
// checked beat by beat against a behavioral line editor kept in the testbench.
// Depends on lerb_pkg and line_editor_ring_buffer_core.
module line_editor_ring_buffer_core_test;
  import lerb_pkg::*;

  localparam int RING_SIZE = 2048;
  localparam logic [3:0] KIND_UNUSED_LO = 4'hA;
  localparam logic [3:0] KIND_UNUSED_HI = 4'hF;

  typedef struct packed {
    in_item_t  key;
    out_item_t want;
  } key_step_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_write = 1'b0;
  logic      cfg_index = 1'b0;
  logic      cfg_data = 1'b0;
  logic      item_valid = 1'b0;
  logic      item_stall;
  in_item_t  item = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  out_item_t result;

  key_step_t key_queue[$];
  out_item_t result_queue[$];
  key_step_t in_flight;
  out_item_t expected_beat;
  int        idle_pct = 38;
  int        failures = 0;
  int        results_checked = 0;
  int        events_sent = 0;
  int        full_refusals = 0;

  logic [7:0]  ring_chars [RING_SIZE];
  bit          chars_valid [RING_SIZE];
  logic [10:0] tail_idx = '0;
  logic [10:0] head_idx = '0;
  logic [10:0] last_line_idx = '0;
  logic [10:0] cursor_gap = '0;
  logic        en_input = 1'b1;
  logic        en_edit = 1'b0;

  line_editor_ring_buffer_core #(
    .RING_DEPTH(RING_SIZE)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  function automatic bit store_char(input logic [7:0] c);
    logic [10:0] idx;
    logic [10:0] stop_idx;
    logic [10:0] gap;
    if (tail_idx + 11'd2 == last_line_idx) begin
      full_refusals++;
      return 1'b0;
    end
    if (en_edit) begin
      gap = (cursor_gap > tail_idx - head_idx) ? tail_idx - head_idx : cursor_gap;
      stop_idx = tail_idx - gap;
      idx = tail_idx;
      while (idx != stop_idx) begin
        ring_chars[idx] = ring_chars[idx - 11'd1];
        chars_valid[idx] = 1'b1;
        idx = idx - 11'd1;
      end
      ring_chars[stop_idx] = c;
      chars_valid[stop_idx] = 1'b1;
    end else begin
      ring_chars[tail_idx] = c;
      chars_valid[tail_idx] = 1'b1;
    end
    tail_idx = tail_idx + 11'd1;
    ring_chars[tail_idx] = CHAR_NUL;
    chars_valid[tail_idx] = 1'b1;
    return 1'b1;
  endfunction

  function automatic void drop_char(input logic [10:0] pos);
    logic [10:0] idx;
    idx = pos;
    tail_idx = tail_idx - 11'd1;
    while (idx != tail_idx) begin
      ring_chars[idx] = ring_chars[idx + 11'd1];
      idx = idx + 11'd1;
    end
    ring_chars[tail_idx] = CHAR_NUL;
    chars_valid[tail_idx] = 1'b1;
  endfunction

  function automatic out_item_t predict_step(input in_item_t k);
    out_item_t   r;
    logic [3:0]  kind;
    logic [10:0] len;
    logic [10:0] pos;
    r = '0;
    kind = k.kind;
    len = tail_idx - head_idx;
    if (kind == KIND_READ) begin
      if (k.flush_line) begin
        tail_idx = head_idx;
        ring_chars[tail_idx] = CHAR_NUL;
        chars_valid[tail_idx] = 1'b1;
        cursor_gap = '0;
        r.status = STAT_EDIT;
      end else begin
        pos = last_line_idx + k.read_offset;
        r.read_char = ring_chars[pos];
        r.status = STAT_READ;
      end
    end else if (kind <= KIND_OTHER && en_input) begin
      if (kind == KIND_CHAR && (k.key_value == CHAR_LF || k.key_value == CHAR_CR)) begin
        kind = KIND_ENTER;
      end
      case (kind)
        KIND_CHAR: begin
          if (k.key_value != CHAR_NUL && store_char(k.key_value)) r.status = STAT_EDIT;
        end
        KIND_ENTER: begin
          last_line_idx = head_idx;
          cursor_gap = '0;
          void'(store_char(CHAR_NUL));
          head_idx = tail_idx;
          r.status = STAT_LINE;
        end
        default: begin
          if (!en_edit || kind == KIND_OTHER) begin
            r.passed_key = k.key_value;
            r.status = STAT_PASSED;
          end else begin
            r.status = STAT_EDIT;
            case (kind)
              KIND_LEFT: if (cursor_gap < len) cursor_gap = cursor_gap + 11'd1;
              KIND_RIGHT: if (cursor_gap > 0) cursor_gap = cursor_gap - 11'd1;
              KIND_HOME: cursor_gap = len;
              KIND_END: cursor_gap = '0;
              KIND_DELETE: begin
                if (cursor_gap > 0 && cursor_gap <= len) begin
                  cursor_gap = cursor_gap - 11'd1;
                  drop_char(tail_idx - cursor_gap - 11'd1);
                end else begin
                  r.status = STAT_NONE;
                end
              end
              KIND_BACKSPACE: begin
                if (cursor_gap < len) drop_char(tail_idx - cursor_gap - 11'd1);
                else r.status = STAT_NONE;
              end
              default: ;
            endcase
          end
        end
      endcase
    end
    r.line_length = tail_idx - head_idx;
    r.cursor_back = cursor_gap;
    r.line_start = last_line_idx;
    return r;
  endfunction

  function automatic in_item_t key_ev(input logic [3:0] kind, input logic [7:0] value);
    in_item_t ev;
    ev.kind = kind;
    ev.key_value = value;
    ev.read_offset = 11'($urandom);
    ev.flush_line = 1'($urandom);
    return ev;
  endfunction

  function automatic in_item_t read_ev(input logic [10:0] offset, input logic flush);
    in_item_t ev;
    ev.kind = KIND_READ;
    ev.key_value = 8'($urandom);
    ev.read_offset = offset;
    ev.flush_line = flush;
    return ev;
  endfunction

  function automatic logic [7:0] random_char();
    if ($urandom_range(7) == 0) return 8'($urandom);
    return 8'($urandom_range(32, 126));
  endfunction

  // A read must never land on a store entry that was never written, so such a read is
  // redirected to the line end, or turned into a flush if even that is unwritten.
  task automatic send(input in_item_t k);
    in_item_t    ev;
    key_step_t   step;
    logic [10:0] pos;
    ev = k;
    pos = last_line_idx + ev.read_offset;
    if (ev.kind == KIND_READ && !ev.flush_line && !chars_valid[pos]) begin
      ev.read_offset = tail_idx - last_line_idx;
      if (!chars_valid[tail_idx]) ev.flush_line = 1'b1;
    end
    step.key = ev;
    step.want = predict_step(ev);
    key_queue.push_back(step);
    if (ev.kind <= KIND_READ && (en_input || ev.kind == KIND_READ)) events_sent++;
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (key_queue.size() != 0 || item_valid || result_queue.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic val);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_INPUT_ENABLED) en_input = val;
    else en_edit = val;
  endtask

  task automatic random_line(input int max_chars);
    int          n;
    int          i;
    logic [10:0] span;
    n = $urandom_range(0, max_chars);
    for (i = 0; i < n; i++) begin
      if (en_edit && $urandom_range(3) == 0) begin
        send(key_ev(4'($urandom_range(KIND_LEFT, KIND_OTHER)), 8'($urandom)));
      end else begin
        send(key_ev(KIND_CHAR, random_char()));
      end
    end
    case ($urandom_range(3))
      0: send(key_ev(KIND_CHAR, CHAR_LF));
      1: send(key_ev(KIND_CHAR, CHAR_CR));
      2: send(read_ev(11'($urandom), 1'b1));
      default: send(key_ev(KIND_ENTER, 8'($urandom)));
    endcase
    span = head_idx - last_line_idx;
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(4) == 0) send(read_ev(11'($urandom), 1'b0));
      else send(read_ev(11'($urandom_range(0, span)), 1'b0));
    end
  endtask

  task automatic random_phase(input logic inp, input logic edit, input int quota);
    int stop_at;
    write_reg(CFG_INPUT_ENABLED, inp);
    write_reg(CFG_EDITING_ON, edit);
    stop_at = events_sent + quota;
    while (events_sent < stop_at) begin
      if ($urandom_range(5) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          send({4'($urandom), 8'($urandom), 11'($urandom), 1'($urandom)});
        end
      end else begin
        random_line(12);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [10:0] want, input logic [10:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failures++;
    end
  endtask

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || !item_stall) begin
      if (item_valid) result_queue.push_back(in_flight.want);
      if (key_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_flight = key_queue.pop_front();
        item <= in_flight.key;
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (result_queue.size() == 0) begin
        $display("%0t ns: result beat with nothing expected, expected none, actual %p",
                 $time, result);
        failures++;
      end else begin
        expected_beat = result_queue.pop_front();
        results_checked++;
        check_field("status", 11'(expected_beat.status), 11'(result.status));
        check_field("passed_key", 11'(expected_beat.passed_key), 11'(result.passed_key));
        check_field("read_char", 11'(expected_beat.read_char), 11'(result.read_char));
        check_field("line_length", expected_beat.line_length, result.line_length);
        check_field("cursor_back", expected_beat.cursor_back, result.cursor_back);
        check_field("line_start", expected_beat.line_start, result.line_start);
      end
    end
  end

  initial begin
    int k;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send(key_ev(KIND_CHAR, 8'h41));
    send(key_ev(KIND_CHAR, 8'hFF));
    send(key_ev(KIND_CHAR, CHAR_NUL));
    send(key_ev(KIND_ENTER, CHAR_NUL));
    send(read_ev(11'd0, 1'b0));
    send(read_ev(11'd2, 1'b0));
    send(key_ev(KIND_CHAR, CHAR_LF));
    send(key_ev(KIND_CHAR, 8'h7A));
    send(key_ev(KIND_CHAR, CHAR_CR));
    send(read_ev(11'd2047, 1'b0));
    for (k = KIND_LEFT; k <= KIND_OTHER; k++) begin
      send(key_ev(4'(k), (k == KIND_LEFT) ? 8'h00 : (k == KIND_OTHER) ? 8'hFF : 8'($urandom)));
    end
    send(key_ev(KIND_CHAR, 8'h71));
    send(read_ev(11'd0, 1'b1));
    send(key_ev(KIND_UNUSED_LO, 8'h55));
    send(key_ev(KIND_UNUSED_HI, 8'hAA));

    write_reg(CFG_INPUT_ENABLED, 1'b0);
    send(key_ev(KIND_CHAR, 8'h62));
    send(key_ev(KIND_ENTER, 8'h00));
    send(key_ev(KIND_OTHER, 8'h80));
    send(read_ev(11'd0, 1'b0));
    send(read_ev(11'd0, 1'b1));
    write_reg(CFG_INPUT_ENABLED, 1'b1);

    write_reg(CFG_EDITING_ON, 1'b1);
    for (k = 0; k < 4; k++) send(key_ev(KIND_CHAR, 8'(8'h61 + k)));
    send(key_ev(KIND_LEFT, 8'h01));
    send(key_ev(KIND_LEFT, 8'h01));
    send(key_ev(KIND_CHAR, 8'h58));
    send(key_ev(KIND_DELETE, 8'h02));
    send(key_ev(KIND_BACKSPACE, 8'h03));
    send(key_ev(KIND_HOME, 8'h04));
    send(key_ev(KIND_BACKSPACE, 8'h03));
    send(key_ev(KIND_LEFT, 8'h01));
    send(key_ev(KIND_END, 8'h05));
    send(key_ev(KIND_DELETE, 8'h02));
    send(key_ev(KIND_RIGHT, 8'h06));
    send(key_ev(KIND_OTHER, 8'h7F));
    send(key_ev(KIND_HOME, 8'h04));
    send(key_ev(KIND_CHAR, 8'h53));
    send(key_ev(KIND_ENTER, 8'h00));
    send(read_ev(11'd0, 1'b0));

    random_phase(1'b1, 1'b1, 40);
    random_phase(1'b1, 1'b0, 30);
    idle_pct = 0;
    random_phase(1'b1, 1'b1, 35);
    idle_pct = 38;
    random_phase(1'b0, 1'b1, 3);
    random_phase(1'b0, 1'b0, 2);
    random_phase(1'b1, 1'b1, 35);
    random_phase(1'b1, 1'b0, 25);
    random_phase(1'b1, 1'b1, 20);

    wait_idle();
    repeat (64) @(posedge clk);
    if (result_queue.size() != 0) begin
      $display("%0t ns: expected %0d more result beats, actual 0", $time, result_queue.size());
      failures++;
    end
    $display("Checked %0d result beats from %0d key events under all input and editing settings.",
             results_checked, events_sent);
    $display("Characters refused on a full ring: %0d; mismatches seen: %0d.",
             full_refusals, failures);
    if (failures == 0) begin
      $display("line_editor_ring_buffer_core regression: pass");
    end else begin
      $display("line_editor_ring_buffer_core regression: fail");
    end
    $finish;
  end

  initial begin
    #250_000_000;
    $display("Timed out with %0d key events and %0d result beats still outstanding.",
             key_queue.size(), result_queue.size());
    $display("line_editor_ring_buffer_core regression: fail");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/lerb_pkg.sv
design/lerb_store.sv
design/lerb_ctrl.sv
design/line_editor_ring_buffer_core.sv
sim/line_editor_ring_buffer_core_test.sv
